[rtl/kmsd_pkg.sv]
// Shared types, constants and helper functions for the key matrix scanner.
`timescale 1ns / 1ps

package kmsd_pkg;

   localparam int unsigned ColWidth     = 5;
   localparam int unsigned RowWidth     = 8;
   localparam int unsigned DriveWidth   = 7;
   localparam int unsigned CountWidth   = 8;
   localparam logic [DriveWidth-1:0] IdleDrive = 7'h7F;
   localparam logic [7:0] SettleReset  = 8'd5;

   typedef struct packed {
      logic [ColWidth-1:0] col_index;
      logic [RowWidth-1:0] row_lines;
      logic                pass_end;
   } kmsd_item_type;

   typedef struct packed {
      logic [DriveWidth-1:0] col_drive;
      logic [RowWidth-1:0]   committed_bits;
      logic                  settling;
      logic                  commit_done;
      logic [CountWidth-1:0] key_count;
   } kmsd_result_type;

   // Column drive codes; anything past the table selects no column.
   function automatic logic [DriveWidth-1:0] drive_code(input logic [ColWidth-1:0] col);
      logic [DriveWidth-1:0] code;
      case (col)
         5'd0:    code = 7'h64;
         5'd1:    code = 7'h6C;
         5'd2:    code = 7'h62;
         5'd3:    code = 7'h7A;
         5'd4:    code = 7'h66;
         5'd5:    code = 7'h76;
         5'd6:    code = 7'h6E;
         5'd7:    code = 7'h7E;
         5'd8:    code = 7'h41;
         5'd9:    code = 7'h21;
         5'd10:   code = 7'h6A;
         5'd11:   code = 7'h72;
         5'd12:   code = 7'h7C;
         5'd13:   code = 7'h74;
         5'd14:   code = 7'h78;
         5'd15:   code = 7'h70;
         5'd16:   code = 7'h60;
         5'd17:   code = 7'h68;
         default: code = IdleDrive;
      endcase
      return code;
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b000, v[i]};
      end
      return n;
   endfunction

endpackage

[rtl/kmsd_core.sv]
// Raw and committed key stores, settle counter and per-column result logic.
`timescale 1ns / 1ps

module kmsd_core
   import kmsd_pkg::*;
#(
   parameter int unsigned ROW_COUNT = 8,
   parameter int unsigned COL_COUNT = 18
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  kmsd_item_type   item,
   input  logic [7:0]      settle_passes,
   output kmsd_result_type result
);

   localparam int unsigned ColIdxW = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;
   localparam logic [ColWidth:0] ColLimit = (ColWidth + 1)'(COL_COUNT);
   localparam logic [CountWidth-1:0] MaxKeys = CountWidth'(ROW_COUNT * COL_COUNT);

   logic [ROW_COUNT-1:0]  raw_ff  [COL_COUNT];
   logic [ROW_COUNT-1:0]  comm_ff [COL_COUNT];
   logic [7:0]            settle_ff, settle_in;
   logic [CountWidth-1:0] raw_count_ff, raw_count_in;
   logic [CountWidth-1:0] comm_count_ff, comm_count_in;

   logic                 in_range, change, commit;
   logic [ColIdxW-1:0]   idx;
   logic [ROW_COUNT-1:0] rows, old_rows;
   logic [7:0]           rows_ext, old_ext, settle_mid;

   always_comb begin
      in_range = {1'b0, item.col_index} < ColLimit;
      idx      = item.col_index[ColIdxW-1:0];
      rows     = ~item.row_lines[ROW_COUNT-1:0];
      old_rows = raw_ff[idx];
      change   = in_range && (old_rows != rows);
      rows_ext = '0;
      old_ext  = '0;
      rows_ext[ROW_COUNT-1:0] = rows;
      old_ext[ROW_COUNT-1:0]  = old_rows;

      // Running raw key total: swap this column's old population for the new.
      raw_count_in = raw_count_ff;
      if (change) begin
         raw_count_in = raw_count_ff + CountWidth'(pop8(rows_ext))
                        - CountWidth'(pop8(old_ext));
      end

      settle_mid = settle_ff;
      if (change) begin
         settle_mid = (settle_passes == 8'd0) ? 8'd1 : settle_passes;
      end
      settle_in = settle_mid;
      commit    = 1'b0;
      if (item.pass_end && settle_mid != 8'd0) begin
         settle_in = settle_mid - 8'd1;
         commit    = (settle_in == 8'd0);
      end

      comm_count_in = commit ? raw_count_in : comm_count_ff;

      result.col_drive      = in_range ? drive_code(item.col_index) : IdleDrive;
      result.committed_bits = '0;
      if (in_range) begin
         result.committed_bits[ROW_COUNT-1:0] = commit ? rows : comm_ff[idx];
      end
      result.settling    = (settle_in != 8'd0);
      result.commit_done = commit;
      result.key_count   = comm_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < COL_COUNT; c++) begin
            raw_ff[c]  <= '0;
            comm_ff[c] <= '0;
         end
         settle_ff     <= SettleReset;
         raw_count_ff  <= '0;
         comm_count_ff <= '0;
      end else if (fire) begin
         if (change) begin
            raw_ff[idx] <= rows;
         end
         if (commit) begin
            for (int c = 0; c < COL_COUNT; c++) begin
               comm_ff[c] <= (change && idx == ColIdxW'(c)) ? rows : raw_ff[c];
            end
         end
         settle_ff     <= settle_in;
         raw_count_ff  <= raw_count_in;
         comm_count_ff <= comm_count_in;
      end
   end

   a_commit_clears_settle: assert property (@(posedge clock) disable iff (reset)
      fire && result.commit_done |-> !result.settling)
      else $error("commit reported while still settling");

   a_commit_copies_count: assert property (@(posedge clock) disable iff (reset)
      fire && result.commit_done |=> comm_count_ff == raw_count_ff)
      else $error("committed key count differs from raw count after commit");

   a_raw_count_bound: assert property (@(posedge clock) disable iff (reset)
      raw_count_ff <= MaxKeys)
      else $error("raw key count beyond matrix size");

   a_idle_column: assert property (@(posedge clock) disable iff (reset)
      fire && !in_range |-> result.committed_bits == '0 && result.col_drive == IdleDrive)
      else $error("out-of-range column produced key data");

endmodule

[rtl/key_matrix_scan_debounce.sv]
// Top level of the key matrix column scanner with global debounce.
`timescale 1ns / 1ps

// Key matrix scanner with global debounce. Feed one beat per scanned column
// (column index, active-low row lines, last-column-of-pass flag); each beat
// returns one beat with the column's drive code, its committed key bits,
// the settle flag, a commit flag and the committed key total. The block
// takes one column per clock unless held by a stall: a beat passes an
// input register and then the store update and result logic into the
// output register, and the next beat may follow in the very next cycle.
// A column whose raw rows change reloads the settle counter from
// csr_settle_passes (zero counts as one); each pass end counts it down and
// on reaching zero the whole raw store is committed at once. Indices
// at or beyond COL_COUNT drive 7F, return zero key bits and still honour
// the pass end. Rows at or above ROW_COUNT are ignored. Write the settle
// register only while no beat is in flight; it is always ready.
module key_matrix_scan_debounce
   import kmsd_pkg::*;
#(
   parameter int unsigned ROW_COUNT = 8,
   parameter int unsigned COL_COUNT = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ColWidth-1:0]   req_col_index,
   input  logic [RowWidth-1:0]   req_row_lines,
   input  logic                  req_pass_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DriveWidth-1:0] rsp_col_drive,
   output logic [RowWidth-1:0]   rsp_committed_bits,
   output logic                  rsp_settling,
   output logic                  rsp_commit_done,
   output logic [CountWidth-1:0] rsp_key_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_settle_passes
);

   logic            s1_valid_ff, s1_valid_in;
   kmsd_item_type   s1_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   kmsd_result_type rsp_data_ff, core_result;
   logic [7:0]      settle_passes_ff;
   logic            out_free, s1_fire, req_take;

   // Output register frees when empty or taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         settle_passes_ff <= SettleReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            settle_passes_ff <= csr_settle_passes;
         end
      end
   end

   // Payload registers: hold while stalled, advance on a taken beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= '{col_index: req_col_index,
                         row_lines: req_row_lines,
                         pass_end:  req_pass_end};
      end
      if (s1_fire) begin
         rsp_data_ff <= core_result;
      end
   end

   kmsd_core #(
      .ROW_COUNT (ROW_COUNT),
      .COL_COUNT (COL_COUNT)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (s1_fire),
      .item          (s1_item_ff),
      .settle_passes (settle_passes_ff),
      .result        (core_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_col_drive      = rsp_data_ff.col_drive;
   assign rsp_committed_bits = rsp_data_ff.committed_bits;
   assign rsp_settling       = rsp_data_ff.settling;
   assign rsp_commit_done    = rsp_data_ff.commit_done;
   assign rsp_key_count      = rsp_data_ff.key_count;

endmodule

[sim/kmsd_checker.sv]
// Checker for the key matrix scanner: predicts each result beat and compares it.
`timescale 1ns / 1ps

module kmsd_checker
   import kmsd_pkg::*;
#(
   parameter int unsigned ROW_COUNT = 8,
   parameter int unsigned COL_COUNT = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [ColWidth-1:0]   req_col_index,
   input  logic [RowWidth-1:0]   req_row_lines,
   input  logic                  req_pass_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [DriveWidth-1:0] rsp_col_drive,
   input  logic [RowWidth-1:0]   rsp_committed_bits,
   input  logic                  rsp_settling,
   input  logic                  rsp_commit_done,
   input  logic [CountWidth-1:0] rsp_key_count,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [7:0]            csr_settle_passes,
   output int unsigned           fault_count,
   output int unsigned           results_due,
   output int unsigned           beats_checked,
   output int unsigned           commits_seen
);

   // Drive codes, column 17 in the top seven bits down to column 0 at the bottom.
   localparam logic [18*DriveWidth-1:0] DRIVE_CODES = {
      7'h68, 7'h60, 7'h70, 7'h78, 7'h74, 7'h7C, 7'h72, 7'h6A, 7'h21,
      7'h41, 7'h7E, 7'h6E, 7'h76, 7'h66, 7'h7A, 7'h62, 7'h6C, 7'h64
   };
   localparam logic [RowWidth-1:0] ROW_MASK = RowWidth'((1 << ROW_COUNT) - 1);

   logic [RowWidth-1:0] raw_rows       [COL_COUNT];
   logic [RowWidth-1:0] committed_rows [COL_COUNT];
   logic [7:0]          settle_left;
   logic [7:0]          settle_setting;
   kmsd_result_type     col_results_due [$];

   task automatic report_fault(input string what);
      fault_count++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_fault($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // Sample one column, then run the pass end handling.
   task automatic scan_column(input logic [ColWidth-1:0] col,
                              input logic [RowWidth-1:0] lines,
                              input logic last_col,
                              output kmsd_result_type res);
      logic [RowWidth-1:0] pressed;
      logic                in_range;
      int unsigned         total;
      pressed  = ~lines & ROW_MASK;
      in_range = col < COL_COUNT;
      res      = '0;
      res.col_drive = IdleDrive;
      if (in_range) begin
         res.col_drive = DRIVE_CODES[col*DriveWidth +: DriveWidth];
         if (raw_rows[col] != pressed) begin
            raw_rows[col] = pressed;
            settle_left   = (settle_setting == 8'd0) ? 8'd1 : settle_setting;
         end
      end
      if (last_col && settle_left != 8'd0) begin
         settle_left--;
         if (settle_left == 8'd0) begin
            for (int c = 0; c < COL_COUNT; c++) begin
               committed_rows[c] = raw_rows[c];
            end
            res.commit_done = 1'b1;
         end
      end
      total = 0;
      for (int c = 0; c < COL_COUNT; c++) begin
         total += $countones(committed_rows[c]);
      end
      if (in_range) begin
         res.committed_bits = committed_rows[col];
      end
      res.settling  = settle_left != 8'd0;
      res.key_count = total[CountWidth-1:0];
   endtask

   always @(posedge clock) begin : watch
      kmsd_result_type want;
      if (reset) begin
         for (int c = 0; c < COL_COUNT; c++) begin
            raw_rows[c]       = '0;
            committed_rows[c] = '0;
         end
         settle_setting = SettleReset;
         settle_left    = SettleReset;
         col_results_due.delete();
         fault_count   = 0;
         beats_checked = 0;
         commits_seen  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            settle_setting = csr_settle_passes;
         end
         if (req_valid && !req_stall) begin
            scan_column(req_col_index, req_row_lines, req_pass_end, want);
            col_results_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (col_results_due.size() == 0) begin
               report_fault("result beat with nothing outstanding");
            end else begin
               want = col_results_due.pop_front();
               check_field("col_drive", rsp_col_drive, want.col_drive);
               check_field("committed_bits", rsp_committed_bits, want.committed_bits);
               check_field("settling", rsp_settling, want.settling);
               check_field("commit_done", rsp_commit_done, want.commit_done);
               check_field("key_count", rsp_key_count, want.key_count);
               beats_checked++;
               if (want.commit_done) begin
                  commits_seen++;
               end
            end
         end
      end
      results_due = col_results_due.size();
   end

endmodule

[sim/tb_top.sv]
// Testbench top for the key matrix scanner: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
   import kmsd_pkg::*;
();

   localparam int unsigned COLS           = 18;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic [ColWidth-1:0]   req_col_index     = '0;
   logic [RowWidth-1:0]   req_row_lines     = '1;
   logic                  req_pass_end      = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic [DriveWidth-1:0] rsp_col_drive;
   logic [RowWidth-1:0]   rsp_committed_bits;
   logic                  rsp_settling;
   logic                  rsp_commit_done;
   logic [CountWidth-1:0] rsp_key_count;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_settle_passes = '0;

   int unsigned fault_count;
   int unsigned results_due;
   int unsigned beats_checked;
   int unsigned commits_seen;

   // Physical key levels per column, active low, as the scan would see them.
   logic [RowWidth-1:0] held_lines [COLS];
   int unsigned         burst_left = 0;
   int unsigned         settings_tried = 0;

   key_matrix_scan_debounce #(
      .ROW_COUNT(8),
      .COL_COUNT(COLS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_col_index      (req_col_index),
      .req_row_lines      (req_row_lines),
      .req_pass_end       (req_pass_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_col_drive      (rsp_col_drive),
      .rsp_committed_bits (rsp_committed_bits),
      .rsp_settling       (rsp_settling),
      .rsp_commit_done    (rsp_commit_done),
      .rsp_key_count      (rsp_key_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_settle_passes  (csr_settle_passes)
   );

   kmsd_checker #(
      .ROW_COUNT(8),
      .COL_COUNT(COLS)
   ) result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_col_index      (req_col_index),
      .req_row_lines      (req_row_lines),
      .req_pass_end       (req_pass_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_col_drive      (rsp_col_drive),
      .rsp_committed_bits (rsp_committed_bits),
      .rsp_settling       (rsp_settling),
      .rsp_commit_done    (rsp_commit_done),
      .rsp_key_count      (rsp_key_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_settle_passes  (csr_settle_passes),
      .fault_count        (fault_count),
      .results_due        (results_due),
      .beats_checked      (beats_checked),
      .commits_seen       (commits_seen)
   );

   initial begin : clock_gen
      forever begin
         #5 clock = ~clock;
      end
   end

   // Present one column beat and hold it until the block takes it. The sender
   // works in bursts: when a burst runs out, drop valid for a random gap
   // (mostly short, now and then long) and pick a fresh burst length, some
   // long enough to give stretches with no idling at all.
   task automatic send_beat(input logic [ColWidth-1:0] col,
                            input logic [RowWidth-1:0] lines,
                            input logic last_col);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 8);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_col_index <= col;
      req_row_lines <= lines;
      req_pass_end  <= last_col;
      // Hold the payload steady through any stall.
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // Stop sending and wait until every outstanding result beat has come back,
   // then allow the pipeline a little slack.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      wait (results_due == 0);
      repeat (4) @(posedge clock);
   endtask

   // Write the settle register; only called with the pipeline empty.
   task automatic write_settle(input logic [7:0] value);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_settle_passes <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_tried++;
   endtask

   // One phase of the random part: drain, set the settle count, then scan.
   // Most beats form well-formed passes (consecutive columns with the pass
   // end flag on the last one) so the settle counter really counts down and
   // commits; keys change now and then, and a share of beats is noise with
   // any column index, any row pattern and any pass end flag.
   task automatic scan_at_setting(input logic [7:0] setting,
                                  input int unsigned count,
                                  input int unsigned max_len,
                                  input int unsigned change_pct,
                                  input int unsigned noise_pct);
      int unsigned sent;
      int unsigned first;
      int unsigned len;
      int unsigned c;
      drain();
      write_settle(setting);
      // Open with a full sweep carrying one fresh key change, which brings
      // the raw store back in line with the held keys after any noise.
      held_lines[$urandom_range(0, COLS - 1)] ^= RowWidth'(1 << $urandom_range(7));
      for (c = 0; c < COLS; c++) begin
         send_beat(ColWidth'(c), held_lines[c], c == COLS - 1);
      end
      sent = COLS;
      while (sent < count) begin
         if ($urandom_range(99) < noise_pct) begin
            send_beat(ColWidth'($urandom_range(0, 31)), RowWidth'($urandom), 1'($urandom));
            sent++;
         end else begin
            len   = (max_len > 1 && $urandom_range(9) == 0) ? COLS
                                                            : $urandom_range(1, max_len);
            first = (len == COLS) ? 0 : $urandom_range(0, COLS - len);
            for (c = first; c < first + len; c++) begin
               if ($urandom_range(99) < change_pct) begin
                  case ($urandom_range(3))
                     0:       held_lines[c] = '0;
                     1:       held_lines[c] = '1;
                     default: held_lines[c] ^= RowWidth'(1 << $urandom_range(7));
                  endcase
               end
               send_beat(ColWidth'(c), held_lines[c], c == first + len - 1);
            end
            sent += len;
         end
      end
   endtask

   // Receiver stall pattern: open stretches, choppy stretches of short stall
   // and open runs, and stretches that stall at a regular interval.
   initial begin : rsp_stall_pattern
      int unsigned span;
      int unsigned run;
      forever begin
         span = $urandom_range(20, 120);
         repeat (span) @(negedge clock) rsp_stall <= 1'b0;
         span = $urandom_range(40, 160);
         while (span > 0) begin
            run = $urandom_range(1, 8);
            repeat (run) @(negedge clock) rsp_stall <= 1'b1;
            run = $urandom_range(1, 6);
            repeat (run) @(negedge clock) rsp_stall <= 1'b0;
            span = (span > 14) ? span - 14 : 0;
         end
         span = $urandom_range(30, 90);
         for (run = 0; run < span; run++) begin
            @(negedge clock) rsp_stall <= (run % 3 == 2);
         end
      end
   end

   // Give up when no beat of any channel has moved for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Watchdog expired after %0d cycles without a beat", quiet);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int unsigned c;
      for (c = 0; c < COLS; c++) begin
         held_lines[c] = '1;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, settle count still at its reset value of five.
      // Press every key in one full sweep, then count the settle down with
      // pass ends on out-of-range columns: the commit must bring the full
      // matrix of 144 keys through, and out-of-range columns must still
      // honour the pass end.
      for (c = 0; c < COLS; c++) begin
         send_beat(ColWidth'(c), '0, c == COLS - 1);
      end
      for (c = 0; c < 4; c++) begin
         send_beat(5'd31, 8'h5A, 1'b1);
      end
      // First index past the table: no column driven, rows ignored.
      send_beat(5'd18, 8'h00, 1'b0);
      // Zero settle count behaves as one: a release commits at this pass end.
      drain();
      write_settle(8'd0);
      send_beat(5'd5, 8'hFF, 1'b1);
      for (c = 0; c < COLS; c++) begin
         held_lines[c] = '0;
      end
      held_lines[5] = '1;

      // Random part across a range of settle counts, both extremes included.
      scan_at_setting(8'd1, 80, 4, 10, 10);
      scan_at_setting(8'd255, 280, 1, 0, 0);
      scan_at_setting(8'd2, 80, 4, 15, 10);
      scan_at_setting(8'd0, 60, 3, 20, 10);
      scan_at_setting(8'($urandom_range(3, 254)), 80, 4, 8, 10);
      scan_at_setting(8'd1, 90, 18, 5, 5);
      scan_at_setting(SettleReset, 80, 4, 10, 15);

      // Let the last results come home and the pipeline settle.
      drain();
      repeat (8) @(posedge clock);

      $display("Checked %0d result beats across %0d settle settings, %0d commits seen.",
               beats_checked, settings_tried, commits_seen);
      $display("Included full-matrix presses, out-of-range columns and one- to 18-column passes.");
      if (fault_count == 0 && results_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[key_matrix_scan_debounce.f]
rtl/kmsd_pkg.sv
rtl/kmsd_core.sv
rtl/key_matrix_scan_debounce.sv
sim/kmsd_checker.sv
sim/tb_top.sv
